### rtl/mtfus_pkg.sv
package mtfus_pkg;

	// Port field widths
	localparam int KEY_W = 8;

	// Request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UNLINK,
		S_LINK,
		S_FIX,
		S_DONE
	} state_t;

	// Operation held while the sequencer runs
	typedef enum logic [1:0] {
		OP_POP,
		OP_MOVE,
		OP_NEW
	} op_t;

	// One result item
	typedef struct packed {
		logic [KEY_W-1:0] key_out;
		logic             was_empty;
		logic             was_present;
	} res_t;

endpackage

### rtl/mtfus_req_if.sv
interface mtfus_req_if import mtfus_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [KEY_W-1:0] key_in;

	modport source (output valid, output req_type, output key_in, input ready);
	modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

### rtl/mtfus_res_if.sv
interface mtfus_res_if import mtfus_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_out;
	logic             was_empty;
	logic             was_present;

	modport source (output valid, output key_out, output was_empty, output was_present,
		input ready);
	modport sink   (input valid, input key_out, input was_empty, input was_present,
		output ready);
endinterface

### rtl/move_to_front_unique_stack.sv
// Channel  Dir  Payload                            Transfer
// req      in   req_type, key_in                   req.valid && req.ready
// res      out  key_out, was_empty, was_present    res.valid && res.ready
//
// One request at a time. From a request transfer to its result turning valid:
// push of the top, out-of-range key or pop of an empty stack go straight to
// done; pop unlinks; a new key links and fixes (only links on an empty stack);
// a stacked key moves by unlink, link and fix. The single-port next/prev link
// memories force these steps, as dependent read, unlink and relink writes run
// in turn through the sequencer. Reset clears the presence bits and the top
// pointer at once; the link memories need no clearing. A waiting result holds
// off the next request, which may transfer at the edge where that result leaves.
module move_to_front_unique_stack import mtfus_pkg::*; #(
	parameter int KEY_RANGE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	mtfus_req_if.sink   req,
	mtfus_res_if.source res
);

	// Only keys that fit the key field can ever be stacked
	localparam int DEPTH = (KEY_RANGE < (1 << KEY_W)) ? KEY_RANGE : (1 << KEY_W);
	localparam int AW    = $clog2(DEPTH);

	// A link is {nil flag, key}
	localparam logic [AW:0] LINK_NIL = {1'b1, {AW{1'b0}}};

	state_t state_q, state_d;
	op_t    op_q;
	res_t   res_q;
	logic   res_valid_q;

	logic [AW:0]      top_q;
	logic [DEPTH-1:0] present_q;
	logic [AW-1:0]    key_q;

	// Link memories
	logic [AW:0]   next_mem [DEPTH];
	logic [AW:0]   prev_mem [DEPTH];
	logic [AW:0]   next_rd_q, prev_rd_q;
	logic [AW-1:0] next_addr, prev_addr;
	logic [AW:0]   next_wdata, prev_wdata;
	logic          next_we, prev_we;

	logic          top_nil;
	logic [AW-1:0] top_key;
	logic [AW-1:0] key_idx;
	logic          key_ok, hit, is_top, accept, res_load;

	// Request decode
	assign top_nil = top_q[AW];
	assign top_key = top_q[AW-1:0];
	assign key_idx = req.key_in[AW-1:0];
	assign key_ok  = 32'(req.key_in) < KEY_RANGE;
	assign hit     = present_q[key_idx];
	assign is_top  = !top_nil && (top_key == key_idx);
	assign accept  = req.valid && req.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_POP) begin
						state_d = top_nil ? S_DONE : S_UNLINK;
					end else if (!key_ok || (hit && is_top)) begin
						state_d = S_DONE;
					end else begin
						state_d = hit ? S_UNLINK : S_LINK;
					end
				end
			end
			S_UNLINK: state_d = (op_q == OP_POP) ? S_DONE : S_LINK;
			S_LINK:   state_d = top_nil ? S_DONE : S_FIX;
			S_FIX:    state_d = S_DONE;
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs: handshake and memory port controls
	always_comb begin
		req.ready  = 1'b0;
		res_load   = 1'b0;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_addr  = key_q;
		prev_addr  = key_q;
		next_wdata = LINK_NIL;
		prev_wdata = LINK_NIL;
		case (state_q)
			S_IDLE: begin
				// result register must be free or leaving
				req.ready = !res_valid_q || res.ready;
				next_addr = (req.req_type == REQ_POP) ? top_key : key_idx;
				prev_addr = key_idx;
			end
			S_UNLINK: begin
				if (op_q == OP_POP) begin
					// new top loses its upward link
					if (!next_rd_q[AW]) begin
						prev_we   = 1'b1;
						prev_addr = next_rd_q[AW-1:0];
					end
				end else begin
					// bridge the neighbours over the moved key
					if (!prev_rd_q[AW]) begin
						next_we    = 1'b1;
						next_addr  = prev_rd_q[AW-1:0];
						next_wdata = next_rd_q;
					end
					if (!next_rd_q[AW]) begin
						prev_we    = 1'b1;
						prev_addr  = next_rd_q[AW-1:0];
						prev_wdata = prev_rd_q;
					end
				end
			end
			S_LINK: begin
				next_we    = 1'b1;
				next_wdata = top_q;
				prev_we    = 1'b1;
			end
			S_FIX: begin
				prev_we    = 1'b1;
				prev_addr  = top_key;
				prev_wdata = {1'b0, key_q};
			end
			S_DONE:  res_load = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	// Memories: read-first, registered read
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_addr] <= next_wdata;
		end
		next_rd_q <= next_mem[next_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_addr] <= prev_wdata;
		end
		prev_rd_q <= prev_mem[prev_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_POP;
			top_q       <= LINK_NIL;
			present_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_POP) begin
							op_q <= OP_POP;
						end else if (hit) begin
							op_q <= OP_MOVE;
						end else begin
							op_q <= OP_NEW;
							if (key_ok) begin
								present_q[key_idx] <= 1'b1;
							end
						end
					end
				end
				S_UNLINK: begin
					if (op_q == OP_POP) begin
						top_q              <= next_rd_q;
						present_q[top_key] <= 1'b0;
					end
				end
				S_LINK: begin
					if (top_nil) begin
						top_q <= {1'b0, key_q};
					end
				end
				S_FIX:   top_q <= {1'b0, key_q};
				default: ;
			endcase
		end
	end

	// Request key and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q             <= key_idx;
			res_q.key_out     <= '0;
			res_q.was_empty   <= (req.req_type == REQ_POP) && top_nil;
			res_q.was_present <= (req.req_type == REQ_PUSH) && key_ok && hit;
		end else if (state_q == S_UNLINK && op_q == OP_POP) begin
			res_q.key_out <= KEY_W'(top_key);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.key_out     = res_q.key_out;
	assign res.was_empty   = res_q.was_empty;
	assign res.was_present = res_q.was_present;

endmodule

### sim/move_to_front_unique_stack_test.sv
`timescale 1ns / 100ps

module move_to_front_unique_stack_test import mtfus_pkg::*; ();

	// Request waiting to be driven; drain holds it back until all results are in
	typedef struct {
		logic             req_type;
		logic [KEY_W-1:0] key;
		bit               drain;
	} lru_req_t;

	localparam int RANDOM_ITEMS = 600;
	localparam int STALL_LIMIT  = 1000;

	logic clk;
	logic arst_n;

	mtfus_req_if req_ch ();
	mtfus_res_if res_ch ();

	move_to_front_unique_stack uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	lru_req_t         pending_reqs[$];
	res_t             lru_expected[$];
	logic [KEY_W-1:0] lru_keys[$];    // stack contents, top first
	lru_req_t         next_req;
	res_t             want;
	int               n_total;
	int               n_sent;
	int               n_got;
	int               mismatches;
	int               idle_cycles;
	logic             steady;

	// no idling on either side over a long stretch of the run
	assign steady = (n_sent >= 250) && (n_sent < 400);

	// Move-to-front stack predictor: one result per request
	function automatic res_t lru_apply(logic req_type, logic [KEY_W-1:0] key);
		res_t r;
		int   idx;
		r = '0;
		idx = -1;
		if (req_type == REQ_POP) begin
			if (lru_keys.size() == 0)
				r.was_empty = 1'b1;
			else
				r.key_out = lru_keys.pop_front();
		end else begin
			foreach (lru_keys[i])
				if (lru_keys[i] == key)
					idx = i;
			if (idx >= 0) begin
				r.was_present = 1'b1;
				lru_keys.delete(idx);
			end
			lru_keys.push_front(key);
		end
		return r;
	endfunction

	task automatic add_req(logic req_type, logic [KEY_W-1:0] key, bit drain);
		lru_req_t item;
		item.req_type = req_type;
		item.key = key;
		item.drain = drain;
		pending_reqs.push_back(item);
		n_total++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Request driver: predicts on each transfer, then presents the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_PUSH;
			req_ch.key_in <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				lru_expected.push_back(lru_apply(req_ch.req_type, req_ch.key_in));
				n_sent <= n_sent + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0
						&& !(pending_reqs[0].drain && lru_expected.size() != 0)
						&& (steady || $urandom_range(99) >= 22)) begin
					next_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_req.req_type;
					req_ch.key_in <= next_req.key;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				n_got <= n_got + 1;
				if (lru_expected.size() == 0) begin
					$display("%0t: unexpected result key_out %0d was_empty %0b was_present %0b",
						$time, res_ch.key_out, res_ch.was_empty, res_ch.was_present);
					mismatches++;
				end else begin
					want = lru_expected.pop_front();
					if (res_ch.key_out !== want.key_out) begin
						$display("%0t: key_out expected %0d actual %0d",
							$time, want.key_out, res_ch.key_out);
						mismatches++;
					end
					if (res_ch.was_empty !== want.was_empty) begin
						$display("%0t: was_empty expected %0b actual %0b",
							$time, want.was_empty, res_ch.was_empty);
						mismatches++;
					end
					if (res_ch.was_present !== want.was_present) begin
						$display("%0t: was_present expected %0b actual %0b",
							$time, want.was_present, res_ch.was_present);
						mismatches++;
					end
				end
			end
			res_ch.ready <= steady || ($urandom_range(99) >= 22);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int          episode;
		int          len;
		int          psz;
		bit          full_range;
		logic [KEY_W-1:0] base;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PUSH;
		req_ch.key_in = '0;
		res_ch.ready = 1'b0;
		n_total = 0;
		n_sent = 0;
		n_got = 0;
		mismatches = 0;
		idle_cycles = 0;
		episode = 0;

		// directed: empty pop, extremes, moves from the bottom, push of the top
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_PUSH, 8'd0, 1'b0);
		add_req(REQ_PUSH, 8'd255, 1'b0);
		add_req(REQ_PUSH, 8'd0, 1'b0);
		add_req(REQ_PUSH, 8'd0, 1'b0);
		add_req(REQ_PUSH, 8'd128, 1'b0);
		add_req(REQ_PUSH, 8'd255, 1'b0);
		add_req(REQ_PUSH, 8'd0, 1'b0);
		add_req(REQ_POP, 8'd255, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_PUSH, 8'h55, 1'b0);
		add_req(REQ_PUSH, 8'hAA, 1'b0);
		add_req(REQ_PUSH, 8'h55, 1'b0);
		add_req(REQ_PUSH, 8'h55, 1'b0);
		add_req(REQ_POP, 8'hFF, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);
		add_req(REQ_POP, 8'd0, 1'b0);

		// random episodes over small key pools so that moves and empties recur
		while (n_total < RANDOM_ITEMS + 20) begin
			full_range = ($urandom_range(7) == 0);
			base = KEY_W'($urandom_range(255));
			psz = $urandom_range(12, 2);
			len = $urandom_range(60, 20);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 35)
					add_req(REQ_POP, KEY_W'($urandom_range(255)),
						(i == 0) && (episode % 5 == 0));
				else if (full_range)
					add_req(REQ_PUSH, KEY_W'($urandom_range(255)),
						(i == 0) && (episode % 5 == 0));
				else
					add_req(REQ_PUSH, KEY_W'(32'(base) + $urandom_range(psz - 1)),
						(i == 0) && (episode % 5 == 0));
			end
			// burst of pops past the bottom now and then
			if ($urandom_range(5) == 0)
				for (int i = 0; i < psz + 3; i++)
					add_req(REQ_POP, KEY_W'($urandom_range(255)), 1'b0);
			episode++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_got == n_total);
		repeat (12) @(posedge clk);
		if (lru_expected.size() != 0) begin
			$display("%0t: %0d results still expected", $time, lru_expected.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
